@@ sv/qsst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun tracker package
// Widths, reset values, register indexes and shared types of the quad sensor
// sun tracker.
// ----------------------------------------------------------------------------
package qsst_pkg;

  // Default width of one light reading.
  localparam int LIGHT_BITS_DEF = 16;

  // Field widths.
  localparam int ANGLE_W    = 12;
  localparam int STEP_W     = 4;
  localparam int TICK_W     = 8;
  localparam int LIMIT_W    = 11;
  localparam int MIN_SUM_W  = 18;
  localparam int WINDOW_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Angle saturation bounds, one bit wider than the angle.
  localparam logic signed [ANGLE_W:0] ANGLE_SAT_MAX = 13'sd2047;
  localparam logic signed [ANGLE_W:0] ANGLE_SAT_MIN = -13'sd2048;

  // Tick counter saturation value.
  localparam logic [TICK_W-1:0] TICK_MAX = 8'd255;

  // Reset values of the axis state.
  localparam logic signed [ANGLE_W-1:0] ANGLE_RESET = 12'sd900;
  localparam logic [STEP_W-1:0]         STEP_RESET  = 4'd10;

  // Reset values of the configuration registers.
  localparam logic [MIN_SUM_W-1:0] MIN_LIGHT_SUM_RESET   = 18'd100;
  localparam logic [LIMIT_W-1:0]   TILT_LOW_LIMIT_RESET  = 11'd300;
  localparam logic [LIMIT_W-1:0]   TILT_HIGH_LIMIT_RESET = 11'd1500;
  localparam logic [LIMIT_W-1:0]   PAN_LOW_LIMIT_RESET   = 11'd0;
  localparam logic [LIMIT_W-1:0]   PAN_HIGH_LIMIT_RESET  = 11'd1800;
  localparam logic [WINDOW_W-1:0]  REV_WINDOW_RESET      = 8'd20;
  localparam logic [STEP_W-1:0]    STEP_DEC_RESET        = 4'd2;
  localparam logic [STEP_W-1:0]    FULL_STEP_RESET       = 4'd10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LIGHT_SUM   = 3'd0,
    REG_TILT_LOW_LIMIT  = 3'd1,
    REG_TILT_HIGH_LIMIT = 3'd2,
    REG_PAN_LOW_LIMIT   = 3'd3,
    REG_PAN_HIGH_LIMIT  = 3'd4,
    REG_REV_WINDOW      = 3'd5,
    REG_STEP_DEC        = 3'd6,
    REG_FULL_STEP       = 3'd7
  } cfg_reg_e;

  // Full register set.
  typedef struct packed {
    logic [MIN_SUM_W-1:0] min_light_sum;
    logic [LIMIT_W-1:0]   tilt_low_limit;
    logic [LIMIT_W-1:0]   tilt_high_limit;
    logic [LIMIT_W-1:0]   pan_low_limit;
    logic [LIMIT_W-1:0]   pan_high_limit;
    logic [WINDOW_W-1:0]  reversal_window;
    logic [STEP_W-1:0]    step_decrement;
    logic [STEP_W-1:0]    full_step;
  } cfg_t;

  // Settings seen by one axis.
  typedef struct packed {
    logic [LIMIT_W-1:0]  low_limit;
    logic [LIMIT_W-1:0]  high_limit;
    logic [WINDOW_W-1:0] reversal_window;
    logic [STEP_W-1:0]   step_decrement;
    logic [STEP_W-1:0]   full_step;
  } axis_cfg_t;

endpackage

@@ sv/qsst_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun tracker channels
// Valid/ready channels for light readings, tracker results and register
// writes.
// ----------------------------------------------------------------------------

// Four quadrant light readings per transaction.
interface qsst_in_if #(
  parameter int LIGHT_BITS = qsst_pkg::LIGHT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LIGHT_BITS-1:0] light_top_right;
  logic [LIGHT_BITS-1:0] light_top_left;
  logic [LIGHT_BITS-1:0] light_bottom_left;
  logic [LIGHT_BITS-1:0] light_bottom_right;

  modport source (output valid, light_top_right, light_top_left,
                  light_bottom_left, light_bottom_right, input ready);
  modport sink   (input valid, light_top_right, light_top_left,
                  light_bottom_left, light_bottom_right, output ready);
endinterface

// Angles and steps after one tick.
interface qsst_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qsst_pkg::ANGLE_W-1:0]  pan_angle_out;
  logic signed [qsst_pkg::ANGLE_W-1:0]  tilt_angle_out;
  logic        [qsst_pkg::STEP_W-1:0]   pan_step_out;
  logic        [qsst_pkg::STEP_W-1:0]   tilt_step_out;

  modport source (output valid, pan_angle_out, tilt_angle_out, pan_step_out,
                  tilt_step_out, input ready);
  modport sink   (input valid, pan_angle_out, tilt_angle_out, pan_step_out,
                  tilt_step_out, output ready);
endinterface

// Register write channel.
interface qsst_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [qsst_pkg::CFG_IDX_W-1:0]      index;
  logic [qsst_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/qsst_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun tracker register file
// Holds the eight configuration registers, written through the register
// write channel.
// ----------------------------------------------------------------------------
module qsst_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  qsst_cfg_if.sink       cfg_i,
  output qsst_pkg::cfg_t regs_o
);
  import qsst_pkg::*;

  cfg_t regs_q;
  logic wr_en;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // Register writes, truncated to each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.min_light_sum   <= MIN_LIGHT_SUM_RESET;
      regs_q.tilt_low_limit  <= TILT_LOW_LIMIT_RESET;
      regs_q.tilt_high_limit <= TILT_HIGH_LIMIT_RESET;
      regs_q.pan_low_limit   <= PAN_LOW_LIMIT_RESET;
      regs_q.pan_high_limit  <= PAN_HIGH_LIMIT_RESET;
      regs_q.reversal_window <= REV_WINDOW_RESET;
      regs_q.step_decrement  <= STEP_DEC_RESET;
      regs_q.full_step       <= FULL_STEP_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_MIN_LIGHT_SUM:   regs_q.min_light_sum   <= cfg_i.data[MIN_SUM_W-1:0];
        REG_TILT_LOW_LIMIT:  regs_q.tilt_low_limit  <= cfg_i.data[LIMIT_W-1:0];
        REG_TILT_HIGH_LIMIT: regs_q.tilt_high_limit <= cfg_i.data[LIMIT_W-1:0];
        REG_PAN_LOW_LIMIT:   regs_q.pan_low_limit   <= cfg_i.data[LIMIT_W-1:0];
        REG_PAN_HIGH_LIMIT:  regs_q.pan_high_limit  <= cfg_i.data[LIMIT_W-1:0];
        REG_REV_WINDOW:      regs_q.reversal_window <= cfg_i.data[WINDOW_W-1:0];
        REG_STEP_DEC:        regs_q.step_decrement  <= cfg_i.data[STEP_W-1:0];
        REG_FULL_STEP:       regs_q.full_step       <= cfg_i.data[STEP_W-1:0];
        default:             regs_q                 <= regs_q;
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

@@ sv/qsst_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun tracker axis
// State and one-tick update of one servo axis: deadband test, limit check,
// step restore and shrink on quick reversal, saturating angle update.
// ----------------------------------------------------------------------------
module qsst_axis #(
  parameter int   LIGHT_BITS    = qsst_pkg::LIGHT_BITS_DEF,
  parameter bit   POS_UP        = 1'b1,
  parameter bit   LAST_UP_RESET = 1'b0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                gate_i,
  input  logic signed [LIGHT_BITS+2:0]        diff_i,
  input  logic        [LIGHT_BITS+1:0]        sum_i,
  input  qsst_pkg::axis_cfg_t                 cfg_i,
  output logic signed [qsst_pkg::ANGLE_W-1:0] angle_d_o,
  output logic        [qsst_pkg::STEP_W-1:0]  step_d_o
);
  import qsst_pkg::*;

  // Product width: difference times twenty plus sign room.
  localparam int DW = LIGHT_BITS + 3;
  localparam int PW = DW + 5;

  logic signed [ANGLE_W-1:0] angle_q, angle_d;
  logic        [STEP_W-1:0]  step_q, step_d;
  logic        [TICK_W-1:0]  ticks_q, ticks_d;
  logic                      last_up_q, last_up_d;

  logic signed [PW-1:0]      diff_ext, sum_s, diff_x5, diff_x20;
  logic                      big_diff, pos_side, neg_side;
  logic signed [ANGLE_W:0]   angle_ext, low_ext, high_ext, angle_sum;
  logic                      up_ok, dn_ok, pos_ok, neg_ok;
  logic [STEP_W-1:0]         step_base, step_shrunk, step_mv;
  logic [TICK_W-1:0]         ticks_base, ticks_mv;
  logic                      move, flag, up, reversal;
  logic signed [ANGLE_W-1:0] angle_sat;

  // Scaled difference and light sum for the deadband and restore tests.
  always_comb begin
    diff_ext = PW'(diff_i);
    sum_s    = $signed({{(PW-LIGHT_BITS-2){1'b0}}, sum_i});
    diff_x5  = (diff_ext <<< 2) + diff_ext;
    diff_x20 = (diff_ext <<< 4) + (diff_ext <<< 2);
    big_diff = (diff_x5 > sum_s) || (diff_x5 < -sum_s);
    pos_side = diff_x20 >= sum_s;
    neg_side = diff_x20 <= -sum_s;
  end

  // Limit checks on the current angle.
  always_comb begin
    angle_ext = {angle_q[ANGLE_W-1], angle_q};
    low_ext   = $signed({2'b00, cfg_i.low_limit});
    high_ext  = $signed({2'b00, cfg_i.high_limit});
    up_ok     = angle_ext < high_ext;
    dn_ok     = angle_ext > low_ext;
    pos_ok    = pos_side && (POS_UP ? up_ok : dn_ok);
    neg_ok    = neg_side && (POS_UP ? dn_ok : up_ok);
  end

  // Step restore, move decision and reversal handling.
  always_comb begin
    step_base = big_diff ? cfg_i.full_step : step_q;
    move      = en_i && gate_i && (step_base != '0) && (pos_ok || neg_ok);
    flag      = pos_ok;
    up        = pos_ok ? POS_UP : !POS_UP;
    reversal  = last_up_q != flag;

    if ((ticks_q < cfg_i.reversal_window) && (step_base != '0)) begin
      step_shrunk = (step_base > cfg_i.step_decrement) ?
                    (step_base - cfg_i.step_decrement) : '0;
    end else begin
      step_shrunk = step_base;
    end
    step_mv    = reversal ? step_shrunk : step_base;
    ticks_base = reversal ? '0 : ticks_q;
    ticks_mv   = (ticks_base < TICK_MAX) ? (ticks_base + 1'b1) : ticks_base;
  end

  // Saturating angle update.
  always_comb begin
    angle_sum = up ? (angle_ext + $signed({1'b0, {(ANGLE_W-STEP_W){1'b0}}, step_mv}))
                   : (angle_ext - $signed({1'b0, {(ANGLE_W-STEP_W){1'b0}}, step_mv}));
    if (angle_sum > ANGLE_SAT_MAX) begin
      angle_sat = ANGLE_SAT_MAX[ANGLE_W-1:0];
    end else if (angle_sum < ANGLE_SAT_MIN) begin
      angle_sat = ANGLE_SAT_MIN[ANGLE_W-1:0];
    end else begin
      angle_sat = angle_sum[ANGLE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    angle_d   = angle_q;
    step_d    = step_q;
    ticks_d   = ticks_q;
    last_up_d = last_up_q;
    if (en_i) begin
      step_d = step_base;
    end
    if (move) begin
      angle_d   = angle_sat;
      step_d    = step_mv;
      ticks_d   = ticks_mv;
      last_up_d = flag;
    end
  end

  // Axis state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q   <= ANGLE_RESET;
      step_q    <= STEP_RESET;
      ticks_q   <= '0;
      last_up_q <= LAST_UP_RESET;
    end else begin
      angle_q   <= angle_d;
      step_q    <= step_d;
      ticks_q   <= ticks_d;
      last_up_q <= last_up_d;
    end
  end

  assign angle_d_o = angle_d;
  assign step_d_o  = step_d;

  // The state only changes on a tick.
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> (angle_q == $past(angle_q)) && (step_q == $past(step_q)))
    else $error("axis state changed without a tick");

  // A move always leaves a nonzero tick count.
  a_move_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> ticks_q != '0)
    else $error("tick count zero after a move");

  // Without a move the angle and tick count hold.
  a_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> (ticks_q == $past(ticks_q)) && (angle_q == $past(angle_q)))
    else $error("axis moved without a move decision");

endmodule

@@ sv/quad_sensor_sun_tracker_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad sensor sun tracker step
// Two-axis tracker: each tick of four quadrant light readings moves the pan
// and tilt servo angles toward the brighter side and reports angles and steps.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  in_i     in   valid/ready   four light readings, LIGHT_BITS each
//  out_o    out  valid/ready   pan/tilt angle (12b signed), pan/tilt step (4b)
//  cfg_i    in   valid/ready   register index (3b), write data (18b)
//
//  One tick per cycle sustained while the result side is ready; an accepted
//  transaction moves from the input register into the result register when
//  the result register is empty or draining, and its result is valid there.
//  Axis state is updated in the same cycle that the result register loads.
//  A stalled result holds the input register, and input ready drops only
//  when both registers are full. Reset sets valid flags, axis state and
//  settings but not data registers; register writes are accepted every cycle.
// ----------------------------------------------------------------------------
module quad_sensor_sun_tracker_step #(
  parameter int LIGHT_BITS = qsst_pkg::LIGHT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qsst_in_if.sink    in_i,
  qsst_out_if.source out_o,
  qsst_cfg_if.sink   cfg_i
);
  import qsst_pkg::*;

  localparam int SW = LIGHT_BITS + 2;
  localparam int CW = (SW > MIN_SUM_W) ? SW : MIN_SUM_W;

  cfg_t      regs;
  axis_cfg_t tilt_cfg, pan_cfg;

  // Input register.
  logic                  s1_valid_q;
  logic [LIGHT_BITS-1:0] tr_q, tl_q, bl_q, br_q;

  // Result register.
  logic                      out_valid_q;
  logic signed [ANGLE_W-1:0] pan_angle_q, tilt_angle_q;
  logic        [STEP_W-1:0]  pan_step_q, tilt_step_q;

  logic                      in_fire, s1_fire;
  logic        [SW-1:0]      sum;
  logic signed [SW:0]        tb_diff, rl_diff;
  logic                      light_ok;
  logic signed [ANGLE_W-1:0] pan_angle_d, tilt_angle_d;
  logic        [STEP_W-1:0]  pan_step_d, tilt_step_d;

  qsst_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // Per-axis settings.
  always_comb begin
    tilt_cfg.low_limit       = regs.tilt_low_limit;
    tilt_cfg.high_limit      = regs.tilt_high_limit;
    tilt_cfg.reversal_window = regs.reversal_window;
    tilt_cfg.step_decrement  = regs.step_decrement;
    tilt_cfg.full_step       = regs.full_step;
    pan_cfg.low_limit        = regs.pan_low_limit;
    pan_cfg.high_limit       = regs.pan_high_limit;
    pan_cfg.reversal_window  = regs.reversal_window;
    pan_cfg.step_decrement   = regs.step_decrement;
    pan_cfg.full_step        = regs.full_step;
  end

  // Handshake: the input register moves on whenever the result register
  // is empty or being drained.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tr_q <= in_i.light_top_right;
      tl_q <= in_i.light_top_left;
      bl_q <= in_i.light_bottom_left;
      br_q <= in_i.light_bottom_right;
    end
  end

  // Quadrant sums and differences.
  always_comb begin
    sum      = SW'(tr_q) + SW'(tl_q) + SW'(bl_q) + SW'(br_q);
    tb_diff  = $signed({1'b0, SW'(tr_q) + SW'(tl_q)})
             - $signed({1'b0, SW'(bl_q) + SW'(br_q)});
    rl_diff  = $signed({1'b0, SW'(tr_q) + SW'(br_q)})
             - $signed({1'b0, SW'(bl_q) + SW'(tl_q)});
    light_ok = CW'(sum) >= CW'(regs.min_light_sum);
  end

  // Tilt: a brighter top lowers the angle.
  qsst_axis #(
    .LIGHT_BITS    (LIGHT_BITS),
    .POS_UP        (1'b0),
    .LAST_UP_RESET (1'b1)
  ) u_tilt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_fire),
    .gate_i    (light_ok),
    .diff_i    (tb_diff),
    .sum_i     (sum),
    .cfg_i     (tilt_cfg),
    .angle_d_o (tilt_angle_d),
    .step_d_o  (tilt_step_d)
  );

  // Pan: a brighter right raises the angle.
  qsst_axis #(
    .LIGHT_BITS    (LIGHT_BITS),
    .POS_UP        (1'b1),
    .LAST_UP_RESET (1'b0)
  ) u_pan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_fire),
    .gate_i    (1'b1),
    .diff_i    (rl_diff),
    .sum_i     (sum),
    .cfg_i     (pan_cfg),
    .angle_d_o (pan_angle_d),
    .step_d_o  (pan_step_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pan_angle_q  <= pan_angle_d;
      tilt_angle_q <= tilt_angle_d;
      pan_step_q   <= pan_step_d;
      tilt_step_q  <= tilt_step_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pan_angle_out  = pan_angle_q;
  assign out_o.tilt_angle_out = tilt_angle_q;
  assign out_o.pan_step_out   = pan_step_q;
  assign out_o.tilt_step_out  = tilt_step_q;

  // An empty input register always takes a new transaction.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with an empty input register");

  // An accepted transaction sits in the input register next cycle.
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted transaction lost");

  // A result appears only after the input register handed one over.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a source transaction");

endmodule

@@ sim/quad_sensor_sun_tracker_step_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun tracker step checker
// Watches the light, result and register channels of the tracker, predicts
// angles and steps for every accepted tick and compares them with the results.
// ----------------------------------------------------------------------------
module quad_sensor_sun_tracker_step_check #(
  parameter int LIGHT_BITS = qsst_pkg::LIGHT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  qsst_in_if   in_i,
  qsst_out_if  out_i,
  qsst_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  import qsst_pkg::*;

  // State of one axis at the block's widths.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [STEP_W-1:0]         step;
    logic [TICK_W-1:0]         ticks;
    logic                      last_up;
  } axis_state_t;

  // Angles and steps reported after one tick.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] pan_angle;
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic [STEP_W-1:0]         pan_step;
    logic [STEP_W-1:0]         tilt_step;
  } position_t;

  cfg_t        settings;
  axis_state_t pan_axis;
  axis_state_t tilt_axis;
  position_t   position_q[$];
  position_t   want;
  position_t   got;
  int          mismatch_count;

  // Moves one axis by its step; flag is the new direction, up raises the angle.
  function automatic axis_state_t step_axis(axis_state_t s, logic flag, logic up);
    axis_state_t n;
    int          a;
    n = s;
    if (n.last_up != flag) begin
      n.last_up = flag;
      if (n.ticks < settings.reversal_window && n.step != '0) begin
        n.step = (n.step > settings.step_decrement) ? n.step - settings.step_decrement
                                                    : '0;
      end
      n.ticks = '0;
    end
    if (n.ticks != TICK_MAX) begin
      n.ticks = n.ticks + 1'b1;
    end
    a = up ? int'($signed(n.angle)) + int'(n.step) : int'($signed(n.angle)) - int'(n.step);
    if (a > 2047) a = 2047;
    if (a < -2048) a = -2048;
    n.angle = a[ANGLE_W-1:0];
    return n;
  endfunction

  // Works both axes for one tick and returns the positions after it.
  function automatic position_t advance_tracker(logic [LIGHT_BITS-1:0] tr,
                                                logic [LIGHT_BITS-1:0] tl,
                                                logic [LIGHT_BITS-1:0] bl,
                                                logic [LIGHT_BITS-1:0] br);
    int        sum;
    int        tb;
    int        rl;
    position_t r;
    sum = int'(tr) + int'(tl) + int'(bl) + int'(br);
    tb  = (int'(tr) + int'(tl)) - (int'(bl) + int'(br));
    rl  = (int'(tr) + int'(br)) - (int'(bl) + int'(tl));

    // A large difference restores the full step first.
    if (tb * 5 > sum || tb * 5 < -sum) tilt_axis.step = settings.full_step;
    if (rl * 5 > sum || rl * 5 < -sum) pan_axis.step = settings.full_step;

    // Tilt: a brighter top lowers the angle; held in a dark sky.
    if (tilt_axis.step != '0 && sum >= int'(settings.min_light_sum)) begin
      if (tb * 20 >= sum &&
          int'($signed(tilt_axis.angle)) > int'(settings.tilt_low_limit)) begin
        tilt_axis = step_axis(tilt_axis, 1'b1, 1'b0);
      end else if (tb * 20 <= -sum &&
                   int'($signed(tilt_axis.angle)) < int'(settings.tilt_high_limit)) begin
        tilt_axis = step_axis(tilt_axis, 1'b0, 1'b1);
      end
    end

    // Pan: a brighter right side raises the angle.
    if (pan_axis.step != '0) begin
      if (rl * 20 >= sum &&
          int'($signed(pan_axis.angle)) < int'(settings.pan_high_limit)) begin
        pan_axis = step_axis(pan_axis, 1'b1, 1'b1);
      end else if (rl * 20 <= -sum &&
                   int'($signed(pan_axis.angle)) > int'(settings.pan_low_limit)) begin
        pan_axis = step_axis(pan_axis, 1'b0, 1'b0);
      end
    end

    r.pan_angle  = pan_axis.angle;
    r.tilt_angle = tilt_axis.angle;
    r.pan_step   = pan_axis.step;
    r.tilt_step  = tilt_axis.step;
    return r;
  endfunction

  // Compare results, follow register writes and predict accepted ticks.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings.min_light_sum   = MIN_LIGHT_SUM_RESET;
      settings.tilt_low_limit  = TILT_LOW_LIMIT_RESET;
      settings.tilt_high_limit = TILT_HIGH_LIMIT_RESET;
      settings.pan_low_limit   = PAN_LOW_LIMIT_RESET;
      settings.pan_high_limit  = PAN_HIGH_LIMIT_RESET;
      settings.reversal_window = REV_WINDOW_RESET;
      settings.step_decrement  = STEP_DEC_RESET;
      settings.full_step       = FULL_STEP_RESET;
      pan_axis                 = '{angle: ANGLE_RESET, step: STEP_RESET, ticks: '0,
                                   last_up: 1'b0};
      tilt_axis                = '{angle: ANGLE_RESET, step: STEP_RESET, ticks: '0,
                                   last_up: 1'b1};
      position_q.delete();
      mismatch_count           = 0;
      fail_count_o            <= 0;
      pending_o               <= 0;
    end else begin
      // Result transaction against the oldest prediction.
      if (out_i.valid && out_i.ready) begin
        got.pan_angle  = out_i.pan_angle_out;
        got.tilt_angle = out_i.tilt_angle_out;
        got.pan_step   = out_i.pan_step_out;
        got.tilt_step  = out_i.tilt_step_out;
        if (position_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: pan %0d tilt %0d pan step %0d tilt step %0d",
                     $signed(got.pan_angle), $signed(got.tilt_angle),
                     got.pan_step, got.tilt_step);
          end
        end else begin
          want = position_q.pop_front();
          if (got.pan_angle !== want.pan_angle || got.tilt_angle !== want.tilt_angle ||
              got.pan_step !== want.pan_step || got.tilt_step !== want.tilt_step) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected pan %0d tilt %0d steps %0d/%0d, got pan %0d tilt %0d steps %0d/%0d",
                       $signed(want.pan_angle), $signed(want.tilt_angle),
                       want.pan_step, want.tilt_step,
                       $signed(got.pan_angle), $signed(got.tilt_angle),
                       got.pan_step, got.tilt_step);
            end
          end
        end
      end

      // Register write transaction; values are masked to register width.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_MIN_LIGHT_SUM:   settings.min_light_sum   = cfg_i.data[MIN_SUM_W-1:0];
          REG_TILT_LOW_LIMIT:  settings.tilt_low_limit  = cfg_i.data[LIMIT_W-1:0];
          REG_TILT_HIGH_LIMIT: settings.tilt_high_limit = cfg_i.data[LIMIT_W-1:0];
          REG_PAN_LOW_LIMIT:   settings.pan_low_limit   = cfg_i.data[LIMIT_W-1:0];
          REG_PAN_HIGH_LIMIT:  settings.pan_high_limit  = cfg_i.data[LIMIT_W-1:0];
          REG_REV_WINDOW:      settings.reversal_window = cfg_i.data[WINDOW_W-1:0];
          REG_STEP_DEC:        settings.step_decrement  = cfg_i.data[STEP_W-1:0];
          REG_FULL_STEP:       settings.full_step       = cfg_i.data[STEP_W-1:0];
          default: ;
        endcase
      end

      // Light transaction: one prediction per tick.
      if (in_i.valid && in_i.ready) begin
        position_q.push_back(advance_tracker(in_i.light_top_right, in_i.light_top_left,
                                             in_i.light_bottom_left,
                                             in_i.light_bottom_right));
      end

      fail_count_o <= mismatch_count;
      pending_o    <= position_q.size();
    end
  end

endmodule

@@ sim/quad_sensor_sun_tracker_step_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun tracker step testbench
// Drives directed and random light ticks through the tracker over several
// register settings and idling patterns; the checker judges every result.
// ----------------------------------------------------------------------------
module quad_sensor_sun_tracker_step_test;
  import qsst_pkg::*;

  localparam int LIGHT_BITS  = LIGHT_BITS_DEF;
  localparam int LIGHT_MAX   = (1 << LIGHT_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 140;

  localparam logic [LIGHT_BITS-1:0] LIGHT_DARK = '0;
  localparam logic [LIGHT_BITS-1:0] LIGHT_FULL = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  qsst_in_if #(.LIGHT_BITS(LIGHT_BITS)) light_if ();
  qsst_out_if                           track_if ();
  qsst_cfg_if                           cfg_if ();

  quad_sensor_sun_tracker_step #(.LIGHT_BITS(LIGHT_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (light_if),
    .out_o  (track_if),
    .cfg_i  (cfg_if)
  );

  quad_sensor_sun_tracker_step_check #(.LIGHT_BITS(LIGHT_BITS)) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (light_if),
    .out_i        (track_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock with a 2 ns period.
  always #1 clk_i = ~clk_i;

  // The result side stalls at random.
  always @(posedge clk_i) begin
    track_if.ready <= (int'($urandom_range(99)) >= stall_pct);
  end

  // Watchdog on the run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** quad_sensor_sun_tracker_step: FAILED **");
      $finish;
    end
  end

  function automatic logic [LIGHT_BITS-1:0] clamp_light(int v);
    if (v < 0) return '0;
    if (v > LIGHT_MAX) return LIGHT_MAX[LIGHT_BITS-1:0];
    return v[LIGHT_BITS-1:0];
  endfunction

  // A reading at either end of the range or anywhere in between.
  function automatic logic [LIGHT_BITS-1:0] extreme_light();
    case ($urandom_range(2))
      0: return '0;
      1: return LIGHT_MAX[LIGHT_BITS-1:0];
      default: return clamp_light(int'($urandom_range(0, LIGHT_MAX)));
    endcase
  endfunction

  // One light transaction, after a random gap; valid stays high afterwards.
  task automatic send_reading(input logic [LIGHT_BITS-1:0] tr,
                              input logic [LIGHT_BITS-1:0] tl,
                              input logic [LIGHT_BITS-1:0] bl,
                              input logic [LIGHT_BITS-1:0] br);
    while (int'($urandom_range(99)) < idle_pct) begin
      light_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    light_if.valid              <= 1'b1;
    light_if.light_top_right    <= tr;
    light_if.light_top_left     <= tl;
    light_if.light_bottom_left  <= bl;
    light_if.light_bottom_right <= br;
    do @(posedge clk_i); while (!light_if.ready);
  endtask

  // Readings around a base level with a tilt offset dt and a pan offset dp.
  task automatic send_quad(input int base, input int dt, input int dp, input int jitter);
    send_reading(clamp_light(base + dt + dp + int'($urandom_range(0, jitter))),
                 clamp_light(base + dt - dp + int'($urandom_range(0, jitter))),
                 clamp_light(base - dt - dp + int'($urandom_range(0, jitter))),
                 clamp_light(base - dt + dp + int'($urandom_range(0, jitter))));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic write_settings(input int min_sum,
                                input int tilt_lo,
                                input int tilt_hi,
                                input int pan_lo,
                                input int pan_hi,
                                input int window,
                                input int dec,
                                input int full);
    write_reg(REG_MIN_LIGHT_SUM, CFG_DATA_W'(min_sum));
    write_reg(REG_TILT_LOW_LIMIT, CFG_DATA_W'(tilt_lo));
    write_reg(REG_TILT_HIGH_LIMIT, CFG_DATA_W'(tilt_hi));
    write_reg(REG_PAN_LOW_LIMIT, CFG_DATA_W'(pan_lo));
    write_reg(REG_PAN_HIGH_LIMIT, CFG_DATA_W'(pan_hi));
    write_reg(REG_REV_WINDOW, CFG_DATA_W'(window));
    write_reg(REG_STEP_DEC, CFG_DATA_W'(dec));
    write_reg(REG_FULL_STEP, CFG_DATA_W'(full));
    cfg_if.valid <= 1'b0;
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic drain();
    light_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 85; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 85; end
      default: begin idle_pct = 21; stall_pct = 21; end
    endcase
  endtask

  // Random ticks in segments: mostly a light source drifting around the
  // deadband, with noise, dark skies and extreme readings mixed in.
  task automatic run_phase(input int n_ticks);
    int done;
    int seg_len;
    int mode;
    int base;
    int ct;
    int cp;
    int kt;
    int kp;
    int i;
    done = 0;
    while (done < n_ticks) begin
      seg_len = $urandom_range(10, 80);
      mode    = $urandom_range(0, 9);
      base    = int'($urandom_range(1, 40000)) >> $urandom_range(0, 12);
      ct      = int'($urandom_range(0, 120)) - 60;
      cp      = int'($urandom_range(0, 120)) - 60;
      kt      = ct;
      kp      = cp;
      for (i = 0; i < seg_len && done < n_ticks; i++) begin
        if (mode < 6) begin
          if ($urandom_range(1)) kt = ct + int'($urandom_range(0, 30)) - 15;
          if ($urandom_range(1)) kp = cp + int'($urandom_range(0, 30)) - 15;
          send_quad(base, base * kt / 200, base * kp / 200, base / 40);
        end else if (mode < 8) begin
          send_reading(clamp_light(int'($urandom_range(0, LIGHT_MAX))),
                       clamp_light(int'($urandom_range(0, LIGHT_MAX))),
                       clamp_light(int'($urandom_range(0, LIGHT_MAX))),
                       clamp_light(int'($urandom_range(0, LIGHT_MAX))));
        end else if (mode == 8) begin
          send_reading(clamp_light(int'($urandom_range(0, 60))),
                       clamp_light(int'($urandom_range(0, 60))),
                       clamp_light(int'($urandom_range(0, 60))),
                       clamp_light(int'($urandom_range(0, 60))));
        end else begin
          send_reading(extreme_light(), extreme_light(), extreme_light(), extreme_light());
        end
        done++;
      end
    end
  endtask

  initial begin
    int phase;
    int i;
    rst_ni                       = 1'b0;
    light_if.valid              <= 1'b0;
    light_if.light_top_right    <= '0;
    light_if.light_top_left     <= '0;
    light_if.light_bottom_left  <= '0;
    light_if.light_bottom_right <= '0;
    cfg_if.valid                <= 1'b0;
    cfg_if.index                <= REG_MIN_LIGHT_SUM;
    cfg_if.data                 <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks with the reset settings.
    send_reading(LIGHT_DARK, LIGHT_DARK, LIGHT_DARK, LIGHT_DARK); // all dark: pan creeps up
    send_reading(LIGHT_FULL, LIGHT_FULL, LIGHT_FULL, LIGHT_FULL);
    send_reading(LIGHT_FULL, LIGHT_FULL, LIGHT_DARK, LIGHT_DARK); // top bright
    send_reading(LIGHT_DARK, LIGHT_DARK, LIGHT_FULL, LIGHT_FULL); // quick tilt reversal
    send_reading(LIGHT_FULL, LIGHT_DARK, LIGHT_DARK, LIGHT_FULL); // right bright
    send_reading(LIGHT_DARK, LIGHT_FULL, LIGHT_FULL, LIGHT_DARK); // quick pan reversal
    send_reading(LIGHT_FULL, LIGHT_DARK, LIGHT_DARK, LIGHT_DARK);
    send_reading(LIGHT_DARK, LIGHT_FULL, LIGHT_DARK, LIGHT_DARK);
    send_reading(LIGHT_DARK, LIGHT_DARK, LIGHT_FULL, LIGHT_DARK);
    send_reading(LIGHT_DARK, LIGHT_DARK, LIGHT_DARK, LIGHT_FULL);
    // Deadband edges: diff*20 equal to the sum moves, one less holds.
    send_quad(1000, 50, 0, 0);
    send_quad(1000, 49, 0, 0);
    send_quad(1000, -50, 0, 0);
    send_quad(1000, 0, 50, 0);
    send_quad(1000, 0, -49, 0);
    // Restore edges: diff*5 equal to the sum is not yet large.
    send_quad(1000, 200, 200, 0);
    send_quad(1000, 201, -201, 0);
    // Dark sky just below and at the minimum light sum.
    send_reading(clamp_light(49), clamp_light(49), LIGHT_DARK, LIGHT_DARK);
    send_reading(clamp_light(50), clamp_light(50), LIGHT_DARK, LIGHT_DARK);
    // Quick reversals shrink both steps down to a freeze, then a restore.
    for (i = 0; i < 6; i++) begin
      send_quad(1000, (i % 2) ? 100 : -100, (i % 2) ? -100 : 100, 0);
    end
    send_quad(1000, 300, -300, 0);
    drain();

    // Random phases over several settings and idling patterns.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;  // reset settings
        1, 6: write_settings($urandom_range(0, 262143), $urandom_range(0, 262143),
                             $urandom_range(0, 262143), $urandom_range(0, 262143),
                             $urandom_range(0, 262143), $urandom_range(0, 262143),
                             $urandom_range(0, 262143), $urandom_range(0, 262143));
        2: write_settings(0, 0, 2047, 0, 2047, 255, 0, 15);
        3: write_settings(262143, 2047, 0, 262143, 0, 0, 15, 0);
        4: write_settings($urandom_range(0, 5000), $urandom_range(850, 950),
                          $urandom_range(850, 950), $urandom_range(850, 950),
                          $urandom_range(850, 950), $urandom_range(0, 255),
                          $urandom_range(0, 15), $urandom_range(0, 15));
        5: write_settings(100, 300, 1500, 0, 1800, $urandom_range(0, 40), 1, 10);
        default: write_settings(int'(MIN_LIGHT_SUM_RESET), int'(TILT_LOW_LIMIT_RESET),
                                int'(TILT_HIGH_LIMIT_RESET), int'(PAN_LOW_LIMIT_RESET),
                                int'(PAN_HIGH_LIMIT_RESET), int'(REV_WINDOW_RESET),
                                int'(STEP_DEC_RESET), int'(FULL_STEP_RESET));
      endcase
      set_idling(phase);
      run_phase(PHASE_TICKS);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("** quad_sensor_sun_tracker_step: PASSED **");
    end else begin
      $display("** quad_sensor_sun_tracker_step: FAILED **");
    end
    $finish;
  end

endmodule
